>>> rtl/core/iabm_pkg.sv
// Shared types, widths and register indexes for the inverse affine blit mapper.
// Used by iabm_regs and inverse_affine_blit_mapper_top; depends on nothing.
package iabm_pkg;

    // Tunable limits of the source rectangle and the fixed-point format.
    localparam int MAX_SRC_DIM = 1024;
    localparam int FRAC_BITS   = 12;

    // Field widths of the register file and the data words.
    localparam int COEF_W    = 18;
    localparam int REL_W     = 12;
    localparam int ORG_W     = 12;
    localparam int DIM_REG_W = 11;
    localparam int SCR_W     = 13;
    localparam int IDX_W     = 20;
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_SEL_W = 3;

    // Effective dimension and in-range coordinate widths.
    localparam int DIM_W = $clog2(MAX_SRC_DIM + 1);
    localparam int POS_W = $clog2(MAX_SRC_DIM);

    // Product, mapped sum and rounded coordinate widths.
    localparam int PROD_W  = COEF_W + REL_W;
    localparam int OFS_W   = DIM_W - 1 + FRAC_BITS;
    localparam int SUM_W   = ((PROD_W + 1 > OFS_W) ? PROD_W + 1 : OFS_W) + 1;
    localparam int RND_W   = SUM_W + 1 - FRAC_BITS;
    localparam int COORD_W = RND_W + 1;

    localparam int S_TDATA_W = ((2 * REL_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 2 * SCR_W + IDX_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_INV_A      = 3'd0,
        REG_INV_B      = 3'd1,
        REG_INV_C      = 3'd2,
        REG_INV_D      = 3'd3,
        REG_ORIGIN_X   = 3'd4,
        REG_ORIGIN_Y   = 3'd5,
        REG_SRC_WIDTH  = 3'd6,
        REG_SRC_HEIGHT = 3'd7
    } reg_sel_t;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic signed [COEF_W-1:0] inv_a;
        logic signed [COEF_W-1:0] inv_b;
        logic signed [COEF_W-1:0] inv_c;
        logic signed [COEF_W-1:0] inv_d;
        logic signed [ORG_W-1:0]  origin_x;
        logic signed [ORG_W-1:0]  origin_y;
        logic [DIM_W-1:0]         src_w;
        logic [DIM_W-1:0]         src_h;
    } cfg_t;

endpackage

>>> rtl/core/inverse_affine_blit_mapper_top.sv
// Inverse affine blit mapper: four-stage datapath from scan point to source index.
// Depends on iabm_pkg and iabm_regs.
//
// Usage: load the inverse matrix (signed Q5.12), the drawing origin and the
// source size through the APB port while no words are in flight. Scan points
// (rel_x, rel_y) then enter on the s_ stream, one word per clock. Each point
// yields one word on the m_ stream with the draw flag in m_tuser and the screen
// position and row-major source index in m_tdata; the index reads zero when
// the point falls outside the source.
// A word's path from acceptance to m_tvalid runs through the four register stages:
// the multiply, the sum with the center offset, the round and range check, and
// the row times width index multiply. Throughput is one word per clock while the
// output is not stalled, as the four register stages all advance together.
// Reset clears the pipeline valid bits and loads the identity matrix, a zero
// origin and a one by one source. When m_tready is low with a word waiting,
// the whole pipeline holds and s_tready drops; nothing is lost or repeated.
module inverse_affine_blit_mapper_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: rel_x [11:0], rel_y [23:12]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iabm_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: screen_x [12:0], screen_y [25:13], src_index [45:26], zero fill
    // m_tuser: draw [0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iabm_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iabm_pkg::ADDR_W-1:0]         paddr,
    input  logic [iabm_pkg::APB_DW-1:0]         pwdata,
    output logic [iabm_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    iabm_pkg::cfg_t cfg;

    iabm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic en;
    logic signed [iabm_pkg::REL_W-1:0] rel_x, rel_y;

    // Stage 1: products and screen position.
    logic                                v1_reg;
    logic signed [iabm_pkg::PROD_W-1:0]  p_ax_reg, p_by_reg, p_cx_reg, p_dy_reg;
    logic signed [iabm_pkg::SCR_W-1:0]   sx1_reg, sy1_reg;
    // Stage 2: mapped coordinates in fixed point.
    logic                                v2_reg;
    logic signed [iabm_pkg::SUM_W-1:0]   u_reg, w_reg;
    logic signed [iabm_pkg::SCR_W-1:0]   sx2_reg, sy2_reg;
    // Stage 3: rounded coordinates and the draw decision.
    logic                                v3_reg, draw3_reg;
    logic [iabm_pkg::POS_W-1:0]          col3_reg, row3_reg;
    logic signed [iabm_pkg::SCR_W-1:0]   sx3_reg, sy3_reg;
    // Stage 4: output word.
    logic                                m_tvalid_reg, draw_o_reg;
    logic [iabm_pkg::IDX_W-1:0]          idx_o_reg;
    logic [iabm_pkg::SCR_W-1:0]          sx_o_reg, sy_o_reg;

    logic signed [iabm_pkg::SUM_W-1:0]   ax_ext, by_ext, cx_ext, dy_ext, ofs_u, ofs_v;
    logic signed [iabm_pkg::COORD_W-1:0] col_s, row_s;
    logic                                draw_next;
    logic [iabm_pkg::POS_W+iabm_pkg::DIM_W-1:0] row_times_w, idx_full;
    logic [iabm_pkg::IDX_W-1:0]          idx_next;

    assign rel_x    = s_tdata[iabm_pkg::REL_W-1:0];
    assign rel_y    = s_tdata[2*iabm_pkg::REL_W-1:iabm_pkg::REL_W];
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Round half away from zero: magnitude plus one half, truncate, restore sign.
    function automatic logic signed [iabm_pkg::COORD_W-1:0] round_fx(
        input logic signed [iabm_pkg::SUM_W-1:0] val
    );
        logic                                  neg;
        logic [iabm_pkg::SUM_W-1:0]            mag;
        logic [iabm_pkg::SUM_W:0]              biased;
        logic [iabm_pkg::COORD_W-1:0]          rnd;
        neg    = val[iabm_pkg::SUM_W-1];
        mag    = neg ? iabm_pkg::SUM_W'(-val) : iabm_pkg::SUM_W'(val);
        biased = (iabm_pkg::SUM_W+1)'(mag)
                 + (iabm_pkg::SUM_W+1)'(1 << (iabm_pkg::FRAC_BITS - 1));
        rnd    = iabm_pkg::COORD_W'(biased[iabm_pkg::SUM_W:iabm_pkg::FRAC_BITS]);
        return neg ? $signed(-rnd) : $signed(rnd);
    endfunction

    function automatic logic in_range(
        input logic signed [iabm_pkg::COORD_W-1:0] pos,
        input logic [iabm_pkg::DIM_W-1:0]          lim
    );
        return !pos[iabm_pkg::COORD_W-1]
               && (pos[iabm_pkg::COORD_W-2:0] < (iabm_pkg::COORD_W-1)'(lim));
    endfunction

    always_comb
    begin
        ax_ext = iabm_pkg::SUM_W'(p_ax_reg);
        by_ext = iabm_pkg::SUM_W'(p_by_reg);
        cx_ext = iabm_pkg::SUM_W'(p_cx_reg);
        dy_ext = iabm_pkg::SUM_W'(p_dy_reg);
        ofs_u  = $signed(iabm_pkg::SUM_W'(cfg.src_w >> 1) << iabm_pkg::FRAC_BITS);
        ofs_v  = $signed(iabm_pkg::SUM_W'(cfg.src_h >> 1) << iabm_pkg::FRAC_BITS);
        col_s  = round_fx(u_reg);
        row_s  = round_fx(w_reg);
        draw_next = in_range(col_s, cfg.src_w) && in_range(row_s, cfg.src_h);
        row_times_w = (iabm_pkg::POS_W+iabm_pkg::DIM_W)'(row3_reg)
                      * (iabm_pkg::POS_W+iabm_pkg::DIM_W)'(cfg.src_w);
        idx_full    = row_times_w + (iabm_pkg::POS_W+iabm_pkg::DIM_W)'(col3_reg);
        idx_next    = draw3_reg ? iabm_pkg::IDX_W'(idx_full) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            m_tvalid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ax_reg  <= iabm_pkg::PROD_W'(cfg.inv_a) * iabm_pkg::PROD_W'(rel_x);
            p_by_reg  <= iabm_pkg::PROD_W'(cfg.inv_b) * iabm_pkg::PROD_W'(rel_y);
            p_cx_reg  <= iabm_pkg::PROD_W'(cfg.inv_c) * iabm_pkg::PROD_W'(rel_x);
            p_dy_reg  <= iabm_pkg::PROD_W'(cfg.inv_d) * iabm_pkg::PROD_W'(rel_y);
            sx1_reg   <= iabm_pkg::SCR_W'(cfg.origin_x) + iabm_pkg::SCR_W'(rel_x);
            sy1_reg   <= iabm_pkg::SCR_W'(cfg.origin_y) + iabm_pkg::SCR_W'(rel_y);

            u_reg     <= ax_ext + by_ext + ofs_u;
            w_reg     <= cx_ext + dy_ext + ofs_v;
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;

            draw3_reg <= draw_next;
            col3_reg  <= col_s[iabm_pkg::POS_W-1:0];
            row3_reg  <= row_s[iabm_pkg::POS_W-1:0];
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;

            draw_o_reg <= draw3_reg;
            idx_o_reg  <= idx_next;
            sx_o_reg   <= sx3_reg;
            sy_o_reg   <= sy3_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = draw_o_reg;
    assign m_tdata  = iabm_pkg::M_TDATA_W'({idx_o_reg, sy_o_reg, sx_o_reg});

`ifndef ASSERT_OFF
    // An undrawn word always carries a zero index.
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> idx_o_reg == '0)
        else $error("src_index nonzero on an undrawn word");

    // While the output is stalled, no stage moves.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({v1_reg, v2_reg, v3_reg, m_tvalid_reg, idx_o_reg}))
        else $error("pipeline advanced during a stall");

    // An accepted word occupies stage one on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted word lost at stage one");

    // A drawn point in stage three lies inside the source.
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && draw3_reg |->
            (iabm_pkg::DIM_W'(col3_reg) < cfg.src_w)
            && (iabm_pkg::DIM_W'(row3_reg) < cfg.src_h))
        else $error("drawn point outside the source");
`endif

endmodule

>>> rtl/core/iabm_regs.sv
// Configuration register file with an APB-style access port.
// Depends on iabm_pkg; feeds the saturated register view to the top level.
module iabm_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iabm_pkg::ADDR_W-1:0]       paddr,
    input  logic [iabm_pkg::APB_DW-1:0]       pwdata,
    output logic [iabm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    output iabm_pkg::cfg_t                    cfg
);

    logic [iabm_pkg::COEF_W-1:0]    inv_a_reg, inv_b_reg, inv_c_reg, inv_d_reg;
    logic [iabm_pkg::ORG_W-1:0]     origin_x_reg, origin_y_reg;
    logic [iabm_pkg::DIM_REG_W-1:0] src_width_reg, src_height_reg;
    iabm_pkg::reg_sel_t             sel;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign sel    = iabm_pkg::reg_sel_t'(paddr[iabm_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_a_reg      <= iabm_pkg::COEF_W'(1 << iabm_pkg::FRAC_BITS);
            inv_b_reg      <= '0;
            inv_c_reg      <= '0;
            inv_d_reg      <= iabm_pkg::COEF_W'(1 << iabm_pkg::FRAC_BITS);
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            src_width_reg  <= iabm_pkg::DIM_REG_W'(1);
            src_height_reg <= iabm_pkg::DIM_REG_W'(1);
        end
        else if (wr_en)
        begin
            case (sel)
                iabm_pkg::REG_INV_A:      inv_a_reg      <= pwdata[iabm_pkg::COEF_W-1:0];
                iabm_pkg::REG_INV_B:      inv_b_reg      <= pwdata[iabm_pkg::COEF_W-1:0];
                iabm_pkg::REG_INV_C:      inv_c_reg      <= pwdata[iabm_pkg::COEF_W-1:0];
                iabm_pkg::REG_INV_D:      inv_d_reg      <= pwdata[iabm_pkg::COEF_W-1:0];
                iabm_pkg::REG_ORIGIN_X:   origin_x_reg   <= pwdata[iabm_pkg::ORG_W-1:0];
                iabm_pkg::REG_ORIGIN_Y:   origin_y_reg   <= pwdata[iabm_pkg::ORG_W-1:0];
                iabm_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[iabm_pkg::DIM_REG_W-1:0];
                iabm_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[iabm_pkg::DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            iabm_pkg::REG_INV_A:      prdata = iabm_pkg::APB_DW'(inv_a_reg);
            iabm_pkg::REG_INV_B:      prdata = iabm_pkg::APB_DW'(inv_b_reg);
            iabm_pkg::REG_INV_C:      prdata = iabm_pkg::APB_DW'(inv_c_reg);
            iabm_pkg::REG_INV_D:      prdata = iabm_pkg::APB_DW'(inv_d_reg);
            iabm_pkg::REG_ORIGIN_X:   prdata = iabm_pkg::APB_DW'(origin_x_reg);
            iabm_pkg::REG_ORIGIN_Y:   prdata = iabm_pkg::APB_DW'(origin_y_reg);
            iabm_pkg::REG_SRC_WIDTH:  prdata = iabm_pkg::APB_DW'(src_width_reg);
            iabm_pkg::REG_SRC_HEIGHT: prdata = iabm_pkg::APB_DW'(src_height_reg);
            default:                  prdata = '0;
        endcase
    end

    // Dimensions above the supported maximum saturate to it.
    always_comb
    begin
        cfg.inv_a    = inv_a_reg;
        cfg.inv_b    = inv_b_reg;
        cfg.inv_c    = inv_c_reg;
        cfg.inv_d    = inv_d_reg;
        cfg.origin_x = origin_x_reg;
        cfg.origin_y = origin_y_reg;
        if (int'(src_width_reg) > iabm_pkg::MAX_SRC_DIM)
            cfg.src_w = iabm_pkg::DIM_W'(iabm_pkg::MAX_SRC_DIM);
        else
            cfg.src_w = iabm_pkg::DIM_W'(src_width_reg);
        if (int'(src_height_reg) > iabm_pkg::MAX_SRC_DIM)
            cfg.src_h = iabm_pkg::DIM_W'(iabm_pkg::MAX_SRC_DIM);
        else
            cfg.src_h = iabm_pkg::DIM_W'(src_height_reg);
    end

endmodule

>>> bench/inverse_affine_blit_mapper_top_test.sv
// Testbench for inverse_affine_blit_mapper_top: directed and random scan points,
// a local model of the mapping, and a word-by-word checker on the result stream.
// Depends on iabm_pkg and the RTL of the mapper; reads no files.
module inverse_affine_blit_mapper_top_test;

    localparam int POINT_TARGET = 1900;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                       draw;
        logic [iabm_pkg::SCR_W-1:0] screen_x;
        logic [iabm_pkg::SCR_W-1:0] screen_y;
        logic [iabm_pkg::IDX_W-1:0] src_index;
    } mapped_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [iabm_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [iabm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [iabm_pkg::ADDR_W-1:0]    paddr = '0;
    logic [iabm_pkg::APB_DW-1:0]    pwdata = '0;
    logic [iabm_pkg::APB_DW-1:0]    prdata;
    logic                           pready;

    // Register file as the mapper should hold it, masked to each register's width.
    logic [iabm_pkg::APB_DW-1:0] reg_shadow [8];
    mapped_t                     pending_maps [$];
    mapped_t                     got_map;
    mapped_t                     want_map;

    int mismatch_count = 0;
    int points_sent = 0;
    int draws_seen = 0;
    int settings_used = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int ready_phase = 0;
    int cycle_count = 0;

    inverse_affine_blit_mapper_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // rel_x [11:0], rel_y [23:12]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // screen_x [12:0], screen_y [25:13], src_index [45:26]
        .m_tuser  (m_tuser),   // draw [0]
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [iabm_pkg::APB_DW-1:0] reg_mask(input iabm_pkg::reg_sel_t sel);
        case (sel)
            iabm_pkg::REG_INV_A, iabm_pkg::REG_INV_B,
            iabm_pkg::REG_INV_C, iabm_pkg::REG_INV_D:
                return (1 << iabm_pkg::COEF_W) - 1;
            iabm_pkg::REG_ORIGIN_X, iabm_pkg::REG_ORIGIN_Y:
                return (1 << iabm_pkg::ORG_W) - 1;
            default:
                return (1 << iabm_pkg::DIM_REG_W) - 1;
        endcase
    endfunction

    function automatic longint effective_dim(input iabm_pkg::reg_sel_t sel);
        longint d;
        d = longint'(reg_shadow[sel][iabm_pkg::DIM_REG_W-1:0]);
        return (d > iabm_pkg::MAX_SRC_DIM) ? iabm_pkg::MAX_SRC_DIM : d;
    endfunction

    // Round a value with FRAC_BITS fraction bits to nearest, halves away from zero.
    function automatic longint round_half_away(input longint value);
        longint half;
        half = longint'(1) <<< (iabm_pkg::FRAC_BITS - 1);
        if (value >= 0)
            return (value + half) >>> iabm_pkg::FRAC_BITS;
        return -((-value + half) >>> iabm_pkg::FRAC_BITS);
    endfunction

    function automatic mapped_t map_point(input logic signed [iabm_pkg::REL_W-1:0] rx,
                                          input logic signed [iabm_pkg::REL_W-1:0] ry);
        longint  a, b, c, d, w, h, u, v, col, row, sx, sy, idx;
        mapped_t r;
        a = longint'($signed(reg_shadow[iabm_pkg::REG_INV_A][iabm_pkg::COEF_W-1:0]));
        b = longint'($signed(reg_shadow[iabm_pkg::REG_INV_B][iabm_pkg::COEF_W-1:0]));
        c = longint'($signed(reg_shadow[iabm_pkg::REG_INV_C][iabm_pkg::COEF_W-1:0]));
        d = longint'($signed(reg_shadow[iabm_pkg::REG_INV_D][iabm_pkg::COEF_W-1:0]));
        w = effective_dim(iabm_pkg::REG_SRC_WIDTH);
        h = effective_dim(iabm_pkg::REG_SRC_HEIGHT);
        u = a * longint'(rx) + b * longint'(ry) + ((w / 2) <<< iabm_pkg::FRAC_BITS);
        v = c * longint'(rx) + d * longint'(ry) + ((h / 2) <<< iabm_pkg::FRAC_BITS);
        col = round_half_away(u);
        row = round_half_away(v);
        r.draw = (col >= 0) && (row >= 0) && (col < w) && (row < h);
        sx = longint'($signed(reg_shadow[iabm_pkg::REG_ORIGIN_X][iabm_pkg::ORG_W-1:0]))
             + longint'(rx);
        sy = longint'($signed(reg_shadow[iabm_pkg::REG_ORIGIN_Y][iabm_pkg::ORG_W-1:0]))
             + longint'(ry);
        idx = r.draw ? row * w + col : 0;
        r.screen_x = sx[iabm_pkg::SCR_W-1:0];
        r.screen_y = sy[iabm_pkg::SCR_W-1:0];
        r.src_index = idx[iabm_pkg::IDX_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endfunction

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_map.draw = m_tuser;
            got_map.screen_x = m_tdata[iabm_pkg::SCR_W-1:0];
            got_map.screen_y = m_tdata[2*iabm_pkg::SCR_W-1:iabm_pkg::SCR_W];
            got_map.src_index = m_tdata[2*iabm_pkg::SCR_W+iabm_pkg::IDX_W-1:2*iabm_pkg::SCR_W];
            if (pending_maps.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result word with nothing expected, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want_map = pending_maps.pop_front();
                if (want_map.draw)
                    draws_seen++;
                check_field("draw", want_map.draw, got_map.draw);
                check_field("screen_x", $signed(want_map.screen_x), $signed(got_map.screen_x));
                check_field("screen_y", $signed(want_map.screen_y), $signed(got_map.screen_y));
                check_field("src_index", want_map.src_index, got_map.src_index);
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((ready_phase % 8) >= 3);
            default: m_tready <= ($urandom_range(0, 9) < 4);
        endcase
        ready_phase++;
    end

    task automatic reg_write(input iabm_pkg::reg_sel_t sel,
                             input logic [iabm_pkg::APB_DW-1:0] value);
        reg_shadow[sel] = value & reg_mask(sel);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [iabm_pkg::APB_DW-1:0] a,
                                input logic [iabm_pkg::APB_DW-1:0] b,
                                input logic [iabm_pkg::APB_DW-1:0] c,
                                input logic [iabm_pkg::APB_DW-1:0] d,
                                input logic [iabm_pkg::APB_DW-1:0] ox,
                                input logic [iabm_pkg::APB_DW-1:0] oy,
                                input logic [iabm_pkg::APB_DW-1:0] w,
                                input logic [iabm_pkg::APB_DW-1:0] h);
        reg_write(iabm_pkg::REG_INV_A, a);
        reg_write(iabm_pkg::REG_INV_B, b);
        reg_write(iabm_pkg::REG_INV_C, c);
        reg_write(iabm_pkg::REG_INV_D, d);
        reg_write(iabm_pkg::REG_ORIGIN_X, ox);
        reg_write(iabm_pkg::REG_ORIGIN_Y, oy);
        reg_write(iabm_pkg::REG_SRC_WIDTH, w);
        reg_write(iabm_pkg::REG_SRC_HEIGHT, h);
    endtask

    // The sender works in bursts; between bursts a random gap may lower tvalid.
    task automatic send_point(input logic signed [iabm_pkg::REL_W-1:0] rx,
                              input logic signed [iabm_pkg::REL_W-1:0] ry);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0
                : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 12 : 3);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 64 : 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {ry, rx};
        do @(posedge clk); while (!s_tready);
        pending_maps.push_back(map_point(rx, ry));
        points_sent++;
    endtask

    // Every point yields a word, so an empty queue means the pipeline is empty.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_maps.size() != 0);
    endtask

    task automatic check_register_file();
        int i;
        iabm_pkg::reg_sel_t sel;
        for (i = 0; i < 8; i++)
        begin
            sel = iabm_pkg::reg_sel_t'(i);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {sel, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            check_field(sel.name(), reg_shadow[sel], prdata & reg_mask(sel));
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic test_reset_defaults();
        check_register_file();
        send_point(0, 0);
        send_point(1, 0);
        send_point(0, -1);
        send_point(2047, -2048);
    endtask

    task automatic test_field_extremes();
        drain_results();
        load_setting(4096, 0, 0, 4096, 2047, -2048, 1024, 1024);
        send_point(2047, -2048);
        send_point(-2048, 2047);
        send_point(511, 511);
        send_point(-512, -512);
        send_point(512, 0);
        drain_results();
        load_setting(4096, 0, 0, 4096, -2048, 2047, 1024, 1024);
        send_point(-2048, -2048);
        send_point(2047, 2047);
    endtask

    // Just under one half rounds to zero on both sides; exactly one half rounds away.
    task automatic test_rounding_halves();
        drain_results();
        load_setting(2047, 0, 0, 2047, 0, 0, 1, 1);
        send_point(-1, -1);
        send_point(1, 1);
        drain_results();
        load_setting(2048, 0, 0, 2048, 0, 0, 1, 1);
        send_point(-1, -1);
        send_point(1, 1);
        drain_results();
        reg_write(iabm_pkg::REG_SRC_WIDTH, 2);
        reg_write(iabm_pkg::REG_SRC_HEIGHT, 2);
        send_point(-1, -1);
    endtask

    // A zero size draws nothing, a size above the limit saturates, and the
    // coefficients go to both ends of their range.
    task automatic test_dimension_limits();
        drain_results();
        load_setting(4096, 0, 0, 4096, 100, -100, 0, 4);
        send_point(0, 0);
        send_point(0, -2);
        drain_results();
        reg_write(iabm_pkg::REG_SRC_WIDTH, 2047);
        reg_write(iabm_pkg::REG_SRC_HEIGHT, 1500);
        send_point(511, 511);
        send_point(-512, -512);
        drain_results();
        load_setting(-131072, 131071, 131071, -131072, 5, 5, 1024, 1024);
        send_point(0, 0);
        send_point(1, 0);
        send_point(-2048, 2047);
    endtask

    task automatic test_random_phases();
        int phase, kind, n, k, span, rx, ry, i;
        logic [iabm_pkg::APB_DW-1:0] coef [4];
        logic [iabm_pkg::APB_DW-1:0] dim [2];
        phase = 0;
        while (points_sent < POINT_TARGET)
        begin
            drain_results();
            kind = $urandom_range(0, 9);
            for (i = 0; i < 4; i++)
            begin
                if (kind == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       coef[i] = -131072;
                        1:       coef[i] = 131071;
                        2:       coef[i] = 0;
                        default: coef[i] = $urandom_range(0, 262143) - 131072;
                    endcase
                end
                else if (i == 0 || i == 3)
                    coef[i] = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(2048, 8192);
                else
                    coef[i] = $urandom_range(0, 8192) - 4096;
            end
            for (i = 0; i < 2; i++)
            begin
                if (kind == 1)
                begin
                    case ($urandom_range(0, 4))
                        0:       dim[i] = 0;
                        1:       dim[i] = 1;
                        2:       dim[i] = 1024;
                        3:       dim[i] = $urandom_range(1025, 2047);
                        default: dim[i] = $urandom_range(1, 1024);
                    endcase
                end
                else if ($urandom_range(0, 9) < 8)
                    dim[i] = $urandom_range(1, 40);
                else
                    dim[i] = $urandom_range(41, 1024);
            end
            load_setting(coef[0], coef[1], coef[2], coef[3],
                         $urandom_range(0, 4095), $urandom_range(0, 4095), dim[0], dim[1]);
            settings_used++;
            span = int'(effective_dim(iabm_pkg::REG_SRC_WIDTH));
            if (effective_dim(iabm_pkg::REG_SRC_HEIGHT) > span)
                span = int'(effective_dim(iabm_pkg::REG_SRC_HEIGHT));
            span = span / 2 + 2;
            n = $urandom_range(20, 80);
            for (k = 0; k < n; k++)
            begin
                // Mostly points near the source footprint, the rest anywhere.
                if ($urandom_range(0, 9) < 7)
                begin
                    rx = $urandom_range(0, 2 * span) - span;
                    ry = $urandom_range(0, 2 * span) - span;
                end
                else
                begin
                    rx = $urandom_range(0, 4095) - 2048;
                    ry = $urandom_range(0, 4095) - 2048;
                end
                if (phase % 4 == 1 && k == n / 2)
                    drain_results();
                send_point(rx[iabm_pkg::REL_W-1:0], ry[iabm_pkg::REL_W-1:0]);
            end
            phase++;
        end
        drain_results();
        check_register_file();
    endtask

    initial
    begin
        reg_shadow[iabm_pkg::REG_INV_A] = 4096;
        reg_shadow[iabm_pkg::REG_INV_B] = 0;
        reg_shadow[iabm_pkg::REG_INV_C] = 0;
        reg_shadow[iabm_pkg::REG_INV_D] = 4096;
        reg_shadow[iabm_pkg::REG_ORIGIN_X] = 0;
        reg_shadow[iabm_pkg::REG_ORIGIN_Y] = 0;
        reg_shadow[iabm_pkg::REG_SRC_WIDTH] = 1;
        reg_shadow[iabm_pkg::REG_SRC_HEIGHT] = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_rounding_halves();
        test_dimension_limits();
        test_random_phases();
        drain_results();
        repeat (8) @(posedge clk);
        $display("Mapped %0d scan points under %0d random register settings plus directed cases.",
                 points_sent, settings_used);
        $display("%0d points landed inside the source; %0d field mismatches.",
                 draws_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/iabm_pkg.sv
rtl/core/iabm_regs.sv
rtl/core/inverse_affine_blit_mapper_top.sv
bench/inverse_affine_blit_mapper_top_test.sv
